[design/bcp_pkg.sv]
package bcp_pkg;

    localparam int PC_W      = 5;
    localparam int CFG_IDX_W = 3;
    localparam int WIDE_W    = 50;

    localparam logic [PC_W-1:0] PC_OUTER = 5'd13;

    localparam logic signed [32:0] INV_GRAVITY_Q32 = 33'sd444153805;
    localparam logic signed [32:0] DT_Q32          = 33'sd42949673;
    localparam logic signed [31:0] ONE_Q16         = 32'sd65536;
    localparam logic        [16:0] WEIGHT_ONE      = 17'd65536;
    localparam logic signed [31:0] SP_RESET        = 32'sd2130;

    localparam logic        [16:0] RST_FILTER_WEIGHT = 17'd62259;
    localparam logic signed [31:0] RST_REST_ANGLE    = 32'sd2130;
    localparam logic        [31:0] RST_ANGLE_KP      = 32'd65536000;
    localparam logic        [31:0] RST_ANGLE_KD      = 32'd16384;
    localparam logic        [31:0] RST_VEL_KP        = 32'd492;
    localparam logic        [31:0] RST_VEL_KD        = 32'd6554;

    typedef logic signed [WIDE_W-1:0] t_wide;
    typedef logic signed [33:0]       t_aop;
    typedef logic signed [32:0]       t_bop;

    typedef struct packed {
        logic              cmd;
        logic signed [31:0] accel_z;
        logic signed [31:0] gyro_pitch;
        logic signed [31:0] measured_left;
        logic signed [31:0] measured_right;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] left_target;
        logic signed [31:0] right_target;
        logic              targets_valid;
        logic signed [31:0] angle_setpoint;
        logic signed [31:0] tilt_angle;
        logic signed [31:0] angle_error;
        logic              saturated;
    } t_out_word;

    typedef struct packed {
        logic        [16:0] filter_weight;
        logic signed [31:0] rest_angle;
        logic        [31:0] angle_kp;
        logic        [31:0] angle_kd;
        logic        [31:0] vel_kp;
        logic        [31:0] vel_kd;
        logic signed [31:0] wheel_command_left;
        logic signed [31:0] wheel_command_right;
    } t_cfg;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_WEIGHT = 3'd0,
        CFG_REST_ANGLE    = 3'd1,
        CFG_ANGLE_KP      = 3'd2,
        CFG_ANGLE_KD      = 3'd3,
        CFG_VEL_KP        = 3'd4,
        CFG_VEL_KD        = 3'd5,
        CFG_CMD_LEFT      = 3'd6,
        CFG_CMD_RIGHT     = 3'd7
    } t_cfg_idx;

    // multiplier operand A
    typedef enum logic [2:0] {
        A_AZ, A_GP, A_W, A_ERR, A_D, A_F, A_SE
    } t_asel;

    // multiplier operand B
    typedef enum logic [3:0] {
        B_INVG, B_DT, B_WT, B_AKP, B_AKD, B_CML, B_CMR, B_SKP, B_SKD
    } t_bsel;

    // adder sources
    typedef enum logic [4:0] {
        S_ZERO, S_ACC, S_TILT, S_A, S_SP, S_ERR, S_ERR2, S_LERR, S_ONE,
        S_PD, S_ML, S_MR, S_CUR, S_CML, S_SE, S_LSE, S_IDLE
    } t_ssel;

    typedef enum logic [1:0] {
        P_NONE, P_RND16, P_RND32
    } t_pterm;

    typedef enum logic [3:0] {
        D_NONE, D_A, D_W, D_TILT, D_ERR, D_D, D_ACC, D_PD, D_F, D_L, D_R,
        D_CUR, D_SE, D_SP
    } t_dst;

    typedef enum logic [1:0] {
        F_NEXT, F_BR_OUTER, F_EMIT
    } t_flow;

    typedef struct packed {
        logic   mul_en;
        t_asel  asel;
        t_bsel  bsel;
        t_ssel  sx;
        t_ssel  sy;
        logic   sy_neg;
        t_pterm pterm;
        t_dst   dst;
        logic   commit_err;
        logic   commit_se;
        t_flow  flow;
    } t_uword;

    typedef struct packed {
        logic start;
        logic run;
        logic emit;
    } t_seq_ctl;

endpackage

[design/bcp_cfg.sv]
module bcp_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bcp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [31:0]                        i_cfg_data,
    output bcp_pkg::t_cfg                      o_cfg
);

    bcp_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.filter_weight       <= bcp_pkg::RST_FILTER_WEIGHT;
            r_cfg.rest_angle          <= bcp_pkg::RST_REST_ANGLE;
            r_cfg.angle_kp            <= bcp_pkg::RST_ANGLE_KP;
            r_cfg.angle_kd            <= bcp_pkg::RST_ANGLE_KD;
            r_cfg.vel_kp              <= bcp_pkg::RST_VEL_KP;
            r_cfg.vel_kd              <= bcp_pkg::RST_VEL_KD;
            r_cfg.wheel_command_left  <= '0;
            r_cfg.wheel_command_right <= '0;
        end else if (i_cfg_valid) begin
            case (bcp_pkg::t_cfg_idx'(i_cfg_index))
                bcp_pkg::CFG_FILTER_WEIGHT: r_cfg.filter_weight       <= i_cfg_data[16:0];
                bcp_pkg::CFG_REST_ANGLE:    r_cfg.rest_angle          <= i_cfg_data;
                bcp_pkg::CFG_ANGLE_KP:      r_cfg.angle_kp            <= i_cfg_data;
                bcp_pkg::CFG_ANGLE_KD:      r_cfg.angle_kd            <= i_cfg_data;
                bcp_pkg::CFG_VEL_KP:        r_cfg.vel_kp              <= i_cfg_data;
                bcp_pkg::CFG_VEL_KD:        r_cfg.vel_kd              <= i_cfg_data;
                bcp_pkg::CFG_CMD_LEFT:      r_cfg.wheel_command_left  <= i_cfg_data;
                bcp_pkg::CFG_CMD_RIGHT:     r_cfg.wheel_command_right <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

[design/bcp_urom.sv]
module bcp_urom (
    input  logic [bcp_pkg::PC_W-1:0] i_pc,
    output bcp_pkg::t_uword          o_uword
);

    function automatic bcp_pkg::t_uword uop(
        input logic            mul_en,
        input bcp_pkg::t_asel  asel,
        input bcp_pkg::t_bsel  bsel,
        input bcp_pkg::t_ssel  sx,
        input bcp_pkg::t_ssel  sy,
        input logic            sy_neg,
        input bcp_pkg::t_pterm pterm,
        input bcp_pkg::t_dst   dst,
        input logic            commit_err,
        input logic            commit_se,
        input bcp_pkg::t_flow  flow
    );
        bcp_pkg::t_uword w;
        w.mul_en     = mul_en;
        w.asel       = asel;
        w.bsel       = bsel;
        w.sx         = sx;
        w.sy         = sy;
        w.sy_neg     = sy_neg;
        w.pterm      = pterm;
        w.dst        = dst;
        w.commit_err = commit_err;
        w.commit_se  = commit_se;
        w.flow       = flow;
        return w;
    endfunction

    // inner: steps 0..12, outer: steps 13..18
    always_comb begin
        case (i_pc)
            5'd0:  o_uword = uop(1'b1, bcp_pkg::A_AZ, bcp_pkg::B_INVG, bcp_pkg::S_ZERO,
                                 bcp_pkg::S_ZERO, 1'b0, bcp_pkg::P_NONE, bcp_pkg::D_NONE,
                                 1'b0, 1'b0, bcp_pkg::F_BR_OUTER);
            5'd1:  o_uword = uop(1'b1, bcp_pkg::A_GP, bcp_pkg::B_DT, bcp_pkg::S_ZERO,
                                 bcp_pkg::S_ZERO, 1'b0, bcp_pkg::P_RND32, bcp_pkg::D_A,
                                 1'b0, 1'b0, bcp_pkg::F_NEXT);
            // w = g + tilt - a
            5'd2:  o_uword = uop(1'b0, bcp_pkg::A_AZ, bcp_pkg::B_INVG, bcp_pkg::S_TILT,
                                 bcp_pkg::S_A, 1'b1, bcp_pkg::P_RND32, bcp_pkg::D_W,
                                 1'b0, 1'b0, bcp_pkg::F_NEXT);
            5'd3:  o_uword = uop(1'b1, bcp_pkg::A_W, bcp_pkg::B_WT, bcp_pkg::S_ZERO,
                                 bcp_pkg::S_ZERO, 1'b0, bcp_pkg::P_NONE, bcp_pkg::D_NONE,
                                 1'b0, 1'b0, bcp_pkg::F_NEXT);
            // tilt = a + C*(g + tilt - a)
            5'd4:  o_uword = uop(1'b0, bcp_pkg::A_AZ, bcp_pkg::B_INVG, bcp_pkg::S_A,
                                 bcp_pkg::S_ZERO, 1'b0, bcp_pkg::P_RND16, bcp_pkg::D_TILT,
                                 1'b0, 1'b0, bcp_pkg::F_NEXT);
            5'd5:  o_uword = uop(1'b0, bcp_pkg::A_AZ, bcp_pkg::B_INVG, bcp_pkg::S_SP,
                                 bcp_pkg::S_TILT, 1'b1, bcp_pkg::P_NONE, bcp_pkg::D_ERR,
                                 1'b0, 1'b0, bcp_pkg::F_NEXT);
            5'd6:  o_uword = uop(1'b1, bcp_pkg::A_ERR, bcp_pkg::B_AKP, bcp_pkg::S_ONE,
                                 bcp_pkg::S_ERR2, 1'b1, bcp_pkg::P_NONE, bcp_pkg::D_F,
                                 1'b0, 1'b0, bcp_pkg::F_NEXT);
            5'd7:  o_uword = uop(1'b0, bcp_pkg::A_AZ, bcp_pkg::B_INVG, bcp_pkg::S_ERR,
                                 bcp_pkg::S_LERR, 1'b1, bcp_pkg::P_NONE, bcp_pkg::D_D,
                                 1'b0, 1'b0, bcp_pkg::F_NEXT);
            5'd8:  o_uword = uop(1'b1, bcp_pkg::A_D, bcp_pkg::B_AKD, bcp_pkg::S_ZERO,
                                 bcp_pkg::S_ZERO, 1'b0, bcp_pkg::P_RND16, bcp_pkg::D_ACC,
                                 1'b0, 1'b0, bcp_pkg::F_NEXT);
            5'd9:  o_uword = uop(1'b1, bcp_pkg::A_F, bcp_pkg::B_CML, bcp_pkg::S_ACC,
                                 bcp_pkg::S_ZERO, 1'b0, bcp_pkg::P_RND16, bcp_pkg::D_PD,
                                 1'b1, 1'b0, bcp_pkg::F_NEXT);
            5'd10: o_uword = uop(1'b1, bcp_pkg::A_F, bcp_pkg::B_CMR, bcp_pkg::S_PD,
                                 bcp_pkg::S_ZERO, 1'b0, bcp_pkg::P_RND16, bcp_pkg::D_L,
                                 1'b0, 1'b0, bcp_pkg::F_NEXT);
            5'd11: o_uword = uop(1'b0, bcp_pkg::A_AZ, bcp_pkg::B_INVG, bcp_pkg::S_ZERO,
                                 bcp_pkg::S_PD, 1'b1, bcp_pkg::P_RND16, bcp_pkg::D_R,
                                 1'b0, 1'b0, bcp_pkg::F_NEXT);
            5'd12: o_uword = uop(1'b0, bcp_pkg::A_AZ, bcp_pkg::B_INVG, bcp_pkg::S_ZERO,
                                 bcp_pkg::S_ZERO, 1'b0, bcp_pkg::P_NONE, bcp_pkg::D_NONE,
                                 1'b0, 1'b0, bcp_pkg::F_EMIT);
            5'd13: o_uword = uop(1'b0, bcp_pkg::A_AZ, bcp_pkg::B_INVG, bcp_pkg::S_ML,
                                 bcp_pkg::S_MR, 1'b0, bcp_pkg::P_NONE, bcp_pkg::D_CUR,
                                 1'b0, 1'b0, bcp_pkg::F_NEXT);
            5'd14: o_uword = uop(1'b0, bcp_pkg::A_AZ, bcp_pkg::B_INVG, bcp_pkg::S_CML,
                                 bcp_pkg::S_CUR, 1'b1, bcp_pkg::P_NONE, bcp_pkg::D_SE,
                                 1'b0, 1'b0, bcp_pkg::F_NEXT);
            5'd15: o_uword = uop(1'b1, bcp_pkg::A_SE, bcp_pkg::B_SKP, bcp_pkg::S_SE,
                                 bcp_pkg::S_LSE, 1'b1, bcp_pkg::P_NONE, bcp_pkg::D_D,
                                 1'b0, 1'b0, bcp_pkg::F_NEXT);
            5'd16: o_uword = uop(1'b1, bcp_pkg::A_D, bcp_pkg::B_SKD, bcp_pkg::S_ZERO,
                                 bcp_pkg::S_ZERO, 1'b0, bcp_pkg::P_RND16, bcp_pkg::D_ACC,
                                 1'b0, 1'b1, bcp_pkg::F_NEXT);
            5'd17: o_uword = uop(1'b0, bcp_pkg::A_AZ, bcp_pkg::B_INVG, bcp_pkg::S_ACC,
                                 bcp_pkg::S_IDLE, 1'b0, bcp_pkg::P_RND16, bcp_pkg::D_SP,
                                 1'b0, 1'b0, bcp_pkg::F_NEXT);
            default: o_uword = uop(1'b0, bcp_pkg::A_AZ, bcp_pkg::B_INVG, bcp_pkg::S_ZERO,
                                   bcp_pkg::S_ZERO, 1'b0, bcp_pkg::P_NONE, bcp_pkg::D_NONE,
                                   1'b0, 1'b0, bcp_pkg::F_EMIT);
        endcase
    end

endmodule

[design/bcp_seq.sv]
module bcp_seq (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_outer,
    input  logic                     i_out_blocked,
    input  bcp_pkg::t_uword          i_uword,
    output logic [bcp_pkg::PC_W-1:0] o_pc,
    output bcp_pkg::t_seq_ctl        o_ctl
);

    logic                     r_busy;
    logic                     n_busy;
    logic [bcp_pkg::PC_W-1:0] r_pc;
    logic [bcp_pkg::PC_W-1:0] n_pc;
    logic                     w_accept;
    logic                     w_emit;

    assign w_accept   = i_in_valid && !r_busy;
    assign o_in_stall = r_busy;
    assign o_pc       = r_pc;

    assign o_ctl.start = w_accept;
    assign o_ctl.run   = r_busy;
    assign o_ctl.emit  = w_emit;

    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        w_emit = 1'b0;
        if (w_accept) begin
            n_busy = 1'b1;
            n_pc   = '0;
        end else if (r_busy) begin
            case (i_uword.flow)
                bcp_pkg::F_NEXT: begin
                    n_pc = r_pc + 5'd1;
                end
                bcp_pkg::F_BR_OUTER: begin
                    n_pc = i_outer ? bcp_pkg::PC_OUTER : r_pc + 5'd1;
                end
                bcp_pkg::F_EMIT: begin
                    if (!i_out_blocked) begin
                        w_emit = 1'b1;
                        n_busy = 1'b0;
                    end
                end
                default: begin
                    n_busy = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= '0;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

endmodule

[design/bcp_datapath.sv]
module bcp_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bcp_pkg::t_seq_ctl  i_ctl,
    input  bcp_pkg::t_uword    i_uword,
    input  bcp_pkg::t_in_word  i_in_word,
    input  bcp_pkg::t_cfg      i_cfg,
    output logic               o_outer,
    output bcp_pkg::t_out_word o_result
);

    localparam logic signed [66:0] RND16_HALF = 67'sd32768;
    localparam logic signed [66:0] RND32_HALF = 67'sd2147483648;
    localparam bcp_pkg::t_wide     SAT_MAX    = 50'sd2147483647;
    localparam bcp_pkg::t_wide     SAT_MIN    = -50'sd2147483648;

    // architectural state
    logic signed [31:0] r_tilt;
    logic signed [31:0] r_lerr;
    logic signed [31:0] r_lse;
    logic signed [31:0] r_sp;
    logic               r_sat;

    // scratch
    bcp_pkg::t_in_word  r_in;
    logic signed [66:0] r_prod;
    bcp_pkg::t_wide     r_acc;
    logic signed [33:0] r_w;
    logic signed [31:0] r_a;
    logic signed [31:0] r_err;
    logic signed [31:0] r_d;
    logic signed [31:0] r_pd;
    logic signed [31:0] r_f;
    logic signed [31:0] r_l;
    logic signed [31:0] r_r;
    logic signed [31:0] r_cur;
    logic signed [31:0] r_se;

    logic        [16:0] w_weight;
    bcp_pkg::t_aop      w_aop;
    bcp_pkg::t_bop      w_bop;
    logic signed [66:0] w_prod;
    logic signed [66:0] w_r16_full;
    logic signed [66:0] w_r32_full;
    bcp_pkg::t_wide     w_pt;
    bcp_pkg::t_wide     w_sx;
    bcp_pkg::t_wide     w_sy;
    bcp_pkg::t_wide     w_sum;
    logic               w_clip;
    logic signed [31:0] w_sat;
    logic               w_sat_dst;

    function automatic bcp_pkg::t_wide src(input bcp_pkg::t_ssel sel);
        bcp_pkg::t_wide v;
        case (sel)
            bcp_pkg::S_ZERO: v = '0;
            bcp_pkg::S_ACC:  v = r_acc;
            bcp_pkg::S_TILT: v = bcp_pkg::t_wide'(r_tilt);
            bcp_pkg::S_A:    v = bcp_pkg::t_wide'(r_a);
            bcp_pkg::S_SP:   v = bcp_pkg::t_wide'(r_sp);
            bcp_pkg::S_ERR:  v = bcp_pkg::t_wide'(r_err);
            bcp_pkg::S_ERR2: v = bcp_pkg::t_wide'(r_err) <<< 1;
            bcp_pkg::S_LERR: v = bcp_pkg::t_wide'(r_lerr);
            bcp_pkg::S_ONE:  v = bcp_pkg::t_wide'(bcp_pkg::ONE_Q16);
            bcp_pkg::S_PD:   v = bcp_pkg::t_wide'(r_pd);
            bcp_pkg::S_ML:   v = bcp_pkg::t_wide'(r_in.measured_left);
            bcp_pkg::S_MR:   v = bcp_pkg::t_wide'(r_in.measured_right);
            bcp_pkg::S_CUR:  v = bcp_pkg::t_wide'(r_cur);
            bcp_pkg::S_CML:  v = bcp_pkg::t_wide'(i_cfg.wheel_command_left);
            bcp_pkg::S_SE:   v = bcp_pkg::t_wide'(r_se);
            bcp_pkg::S_LSE:  v = bcp_pkg::t_wide'(r_lse);
            bcp_pkg::S_IDLE: v = bcp_pkg::t_wide'(i_cfg.rest_angle);
            default:         v = '0;
        endcase
        return v;
    endfunction

    assign w_weight = (i_cfg.filter_weight > bcp_pkg::WEIGHT_ONE) ?
                      bcp_pkg::WEIGHT_ONE : i_cfg.filter_weight;

    always_comb begin
        case (i_uword.asel)
            bcp_pkg::A_AZ:  w_aop = bcp_pkg::t_aop'(r_in.accel_z);
            bcp_pkg::A_GP:  w_aop = bcp_pkg::t_aop'(r_in.gyro_pitch);
            bcp_pkg::A_W:   w_aop = r_w;
            bcp_pkg::A_ERR: w_aop = bcp_pkg::t_aop'(r_err);
            bcp_pkg::A_D:   w_aop = bcp_pkg::t_aop'(r_d);
            bcp_pkg::A_F:   w_aop = bcp_pkg::t_aop'(r_f);
            bcp_pkg::A_SE:  w_aop = bcp_pkg::t_aop'(r_se);
            default:        w_aop = '0;
        endcase
    end

    always_comb begin
        case (i_uword.bsel)
            bcp_pkg::B_INVG: w_bop = bcp_pkg::INV_GRAVITY_Q32;
            bcp_pkg::B_DT:   w_bop = bcp_pkg::DT_Q32;
            bcp_pkg::B_WT:   w_bop = bcp_pkg::t_bop'({16'd0, w_weight});
            bcp_pkg::B_AKP:  w_bop = bcp_pkg::t_bop'({1'b0, i_cfg.angle_kp});
            bcp_pkg::B_AKD:  w_bop = bcp_pkg::t_bop'({1'b0, i_cfg.angle_kd});
            bcp_pkg::B_CML:  w_bop = bcp_pkg::t_bop'(i_cfg.wheel_command_left);
            bcp_pkg::B_CMR:  w_bop = bcp_pkg::t_bop'(i_cfg.wheel_command_right);
            bcp_pkg::B_SKP:  w_bop = bcp_pkg::t_bop'({1'b0, i_cfg.vel_kp});
            bcp_pkg::B_SKD:  w_bop = bcp_pkg::t_bop'({1'b0, i_cfg.vel_kd});
            default:         w_bop = '0;
        endcase
    end

    assign w_prod = w_aop * w_bop;

    // round half up, then floor shift
    assign w_r16_full = (r_prod + RND16_HALF) >>> 16;
    assign w_r32_full = (r_prod + RND32_HALF) >>> 32;

    always_comb begin
        case (i_uword.pterm)
            bcp_pkg::P_NONE:  w_pt = '0;
            bcp_pkg::P_RND16: w_pt = bcp_pkg::t_wide'(w_r16_full[bcp_pkg::WIDE_W-1:0]);
            bcp_pkg::P_RND32: w_pt = bcp_pkg::t_wide'(w_r32_full[bcp_pkg::WIDE_W-1:0]);
            default:          w_pt = '0;
        endcase
    end

    always_comb begin
        w_sx = src(i_uword.sx);
        w_sy = src(i_uword.sy);
    end

    assign w_sum  = w_sx + (i_uword.sy_neg ? -w_sy : w_sy) + w_pt;
    assign w_clip = (w_sum > SAT_MAX) || (w_sum < SAT_MIN);
    assign w_sat  = w_clip ? (w_sum[bcp_pkg::WIDE_W-1] ? 32'sh80000000 : 32'sh7fffffff)
                           : w_sum[31:0];

    always_comb begin
        case (i_uword.dst)
            bcp_pkg::D_A, bcp_pkg::D_TILT, bcp_pkg::D_ERR, bcp_pkg::D_D,
            bcp_pkg::D_PD, bcp_pkg::D_F, bcp_pkg::D_L, bcp_pkg::D_R,
            bcp_pkg::D_SE, bcp_pkg::D_SP: w_sat_dst = 1'b1;
            default:                      w_sat_dst = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tilt <= '0;
            r_lerr <= '0;
            r_lse  <= '0;
            r_sp   <= bcp_pkg::SP_RESET;
            r_sat  <= 1'b0;
        end else if (i_ctl.start) begin
            r_sat <= 1'b0;
        end else if (i_ctl.run) begin
            if (w_sat_dst && w_clip) begin
                r_sat <= 1'b1;
            end
            if (i_uword.dst == bcp_pkg::D_TILT) begin
                r_tilt <= w_sat;
            end
            if (i_uword.dst == bcp_pkg::D_SP) begin
                r_sp <= w_sat;
            end
            if (i_uword.commit_err) begin
                r_lerr <= r_err;
            end
            if (i_uword.commit_se) begin
                r_lse <= r_se;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_in <= i_in_word;
        end
        if (i_ctl.run) begin
            if (i_uword.mul_en) begin
                r_prod <= w_prod;
            end
            case (i_uword.dst)
                bcp_pkg::D_A:   r_a   <= w_sat;
                bcp_pkg::D_W:   r_w   <= w_sum[33:0];
                bcp_pkg::D_ERR: r_err <= w_sat;
                bcp_pkg::D_D:   r_d   <= w_sat;
                bcp_pkg::D_ACC: r_acc <= w_sum;
                bcp_pkg::D_PD:  r_pd  <= w_sat;
                bcp_pkg::D_F:   r_f   <= w_sat;
                bcp_pkg::D_L:   r_l   <= w_sat;
                bcp_pkg::D_R:   r_r   <= w_sat;
                bcp_pkg::D_CUR: r_cur <= w_sum[32:1];
                bcp_pkg::D_SE:  r_se  <= w_sat;
                default: ;
            endcase
        end
    end

    assign o_outer = r_in.cmd;

    assign o_result.left_target    = r_in.cmd ? '0 : r_l;
    assign o_result.right_target   = r_in.cmd ? '0 : r_r;
    assign o_result.targets_valid  = !r_in.cmd;
    assign o_result.angle_setpoint = r_sp;
    assign o_result.tilt_angle     = r_tilt;
    assign o_result.angle_error    = r_lerr;
    assign o_result.saturated      = r_sat;

endmodule

[design/balance_cascade_pid.sv]
// Two-wheel balance controller, cascaded PD with complementary tilt filter,
// signed Q16.16.
// Input channel (i_in_valid / o_in_stall, i_in_word): cmd 0 is an inner
// angle-loop sample (accel_z, gyro_pitch), cmd 1 an outer speed-loop sample
// (measured_left, measured_right). Each word gives exactly one output word.
// Output channel (o_out_valid / i_out_stall, o_out_word): wheel targets,
// setpoint, tilt, angle error and a saturation flag.
// Config channel (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data):
// ready is always high; write only while the block is idle.
// Sequencing: a microcoded sequencer drives one shared 34x33 multiplier and
// one adder. An inner word runs the inner microcode steps, an outer word the
// outer ones, before its result is loaded into the output register; the next
// word is accepted on the cycle after that. One word is in work at a time.
// Reset clears the sequencer and loads the register and state reset values.
// While the receiver stalls, the output word holds; a finished result waits
// in the sequencer's last step, and the input stays stalled meanwhile.
module balance_cascade_pid (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  bcp_pkg::t_in_word             i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output bcp_pkg::t_out_word            o_out_word,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bcp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);

    bcp_pkg::t_cfg      w_cfg;
    bcp_pkg::t_uword    w_uword;
    bcp_pkg::t_seq_ctl  w_ctl;
    bcp_pkg::t_out_word w_result;
    logic [bcp_pkg::PC_W-1:0] w_pc;
    logic               w_outer;
    logic               w_out_blocked;
    logic               w_cfg_we;

    logic               r_out_valid;
    logic               n_out_valid;
    bcp_pkg::t_out_word r_out_word;

    assign w_cfg_we      = i_cfg_valid && o_cfg_ready;
    assign w_out_blocked = r_out_valid && i_out_stall;

    bcp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (w_cfg_we),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    bcp_urom u_urom (
        .i_pc    (w_pc),
        .o_uword (w_uword)
    );

    bcp_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_outer       (w_outer),
        .i_out_blocked (w_out_blocked),
        .i_uword       (w_uword),
        .o_pc          (w_pc),
        .o_ctl         (w_ctl)
    );

    bcp_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_uword   (w_uword),
        .i_in_word (i_in_word),
        .i_cfg     (w_cfg),
        .o_outer   (w_outer),
        .o_result  (w_result)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_ctl.emit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.emit) begin
            r_out_word <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
